FILE: rtl/ecg_lbc_pkg.sv
// Shared constants, widths and register indexes for the ECG low-pass beat counter.
package ecg_lbc_pkg;

  localparam int SAMPLE_BITS    = 10;
  localparam int COEF_FRAC_BITS = 14;

  localparam int FILT_W  = 12;
  localparam int THR_W   = 11;
  localparam int SETTLE_W = 12;
  localparam int WIN_W   = 16;
  localparam int SCALE_W = 4;
  localparam int CNT_W   = 17;
  localparam int PEAKS_W = 16;
  localparam int RATE_W  = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W  = PEAKS_W + SCALE_W + 1;

  // Accumulator: feedback terms dominate, sample terms stay well below them.
  localparam int ACC_W = COEF_FRAC_BITS + SAMPLE_BITS + 8;

  // Coefficients: value in thousandths times 2^COEF_FRAC_BITS, rounded.
  localparam longint COEF_X0 = (64'sd16   * (64'sd1 <<< COEF_FRAC_BITS) + 64'sd500) / 64'sd1000;
  localparam longint COEF_X1 = (64'sd32   * (64'sd1 <<< COEF_FRAC_BITS) + 64'sd500) / 64'sd1000;
  localparam longint COEF_X2 = (64'sd16   * (64'sd1 <<< COEF_FRAC_BITS) + 64'sd500) / 64'sd1000;
  localparam longint COEF_Y1 = (64'sd1630 * (64'sd1 <<< COEF_FRAC_BITS) + 64'sd500) / 64'sd1000;
  localparam longint COEF_Y2 = (64'sd691  * (64'sd1 <<< COEF_FRAC_BITS) + 64'sd500) / 64'sd1000;

  localparam logic signed [FILT_W-1:0] FILT_MAX = {1'b0, {(FILT_W-1){1'b1}}};
  localparam logic signed [FILT_W-1:0] FILT_MIN = {1'b1, {(FILT_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_SAMPLES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SAMPLES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE     = 2'd3;

  localparam logic [THR_W-1:0]    RST_PEAK_THRESHOLD = 11'd535;
  localparam logic [SETTLE_W-1:0] RST_SETTLE_SAMPLES = 12'd200;
  localparam logic [WIN_W-1:0]    RST_WINDOW_SAMPLES = 16'd3476;
  localparam logic [SCALE_W-1:0]  RST_RATE_SCALE     = 4'd2;

  typedef logic signed [FILT_W-1:0] filt_t;

endpackage

FILE: rtl/ecg_lbc_in_if.sv
// Input channel: one raw ECG sample per transaction.
interface ecg_lbc_in_if
  import ecg_lbc_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/ecg_lbc_out_if.sv
// Output channel: filtered sample, peak flag and window beat rate per transaction.
interface ecg_lbc_out_if
  import ecg_lbc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FILT_W-1:0] filtered;
  logic              peak;
  logic              rate_valid;
  logic [RATE_W-1:0] beat_rate;

  modport source (output valid, output filtered, output peak, output rate_valid,
                  output beat_rate, input ready);
  modport sink   (input valid, input filtered, input peak, input rate_valid,
                  input beat_rate, output ready);
endinterface

FILE: rtl/ecg_lbc_biquad.sv
// Second-order low-pass IIR section with its delay line and output saturation.
module ecg_lbc_biquad
  import ecg_lbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic [SAMPLE_BITS-1:0] x,
  output filt_t                  y,
  output filt_t                  y1,
  output filt_t                  y2
);

  logic [SAMPLE_BITS-1:0] x1;
  logic [SAMPLE_BITS-1:0] x2;

  logic signed [ACC_W-1:0] x0_ext, x1_ext, x2_ext, y1_ext, y2_ext;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_adj;
  logic signed [ACC_W-1:0] q;

  assign x0_ext = $signed(ACC_W'(x));
  assign x1_ext = $signed(ACC_W'(x1));
  assign x2_ext = $signed(ACC_W'(x2));
  assign y1_ext = ACC_W'(y1);
  assign y2_ext = ACC_W'(y2);

  always_comb begin
    acc = ACC_W'(COEF_X0) * x0_ext + ACC_W'(COEF_X1) * x1_ext
        + ACC_W'(COEF_X2) * x2_ext + ACC_W'(COEF_Y1) * y1_ext
        - ACC_W'(COEF_Y2) * y2_ext;
    // Round toward zero: bias negative sums before the arithmetic shift.
    if (acc[ACC_W-1]) begin
      acc_adj = acc + $signed(ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1));
    end else begin
      acc_adj = acc;
    end
    q = acc_adj >>> COEF_FRAC_BITS;
    if (q > ACC_W'(FILT_MAX)) begin
      y = FILT_MAX;
    end else if (q < ACC_W'(FILT_MIN)) begin
      y = FILT_MIN;
    end else begin
      y = q[FILT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (advance) begin
      x1 <= x;
      x2 <= x1;
      y1 <= y;
      y2 <= y1;
    end
  end

endmodule

FILE: rtl/ecg_lowpass_beat_counter_unit.sv
// Top level: input register, biquad filter, peak detect, beat window counter, output register.
//
//  channel  | role          | payload
//  ---------+---------------+---------------------------------------------
//  in_ch    | sink          | sample
//  out_ch   | source        | filtered, peak, rate_valid, beat_rate
//  cfg      | write only    | cfg_we, cfg_index, cfg_data
//
// One transaction per cycle sustained while the output is not stalled; two register stages
// (input register, then filter and counters into the output register).
// The filter feedback and window counters update as an item moves into the output
// register. A stalled output holds the output register and then the input register.
// Synchronous reset clears the pipeline, filter history and counters, and reloads the register defaults.
module ecg_lowpass_beat_counter_unit
  import ecg_lbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ecg_lbc_in_if.sink            in_ch,
  ecg_lbc_out_if.source         out_ch
);

  logic [THR_W-1:0]    peak_threshold;
  logic [SETTLE_W-1:0] settle_samples;
  logic [WIN_W-1:0]    window_samples;
  logic [SCALE_W-1:0]  rate_scale;

  logic                   in_full;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   out_full;
  logic                   advance;

  logic [CNT_W-1:0]   sample_counter, sample_counter_next;
  logic [PEAKS_W-1:0] peak_count, peak_count_next;

  filt_t y, y1, y2;

  logic               counting;
  logic [CNT_W-1:0]   pos;
  logic               peak_hit;
  logic               window_end;
  logic               count_inc;
  logic [PROD_W-1:0]  prod;
  logic [RATE_W-1:0]  rate;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_threshold <= RST_PEAK_THRESHOLD;
      settle_samples <= RST_SETTLE_SAMPLES;
      window_samples <= RST_WINDOW_SAMPLES;
      rate_scale     <= RST_RATE_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PEAK_THRESHOLD: peak_threshold <= cfg_data[THR_W-1:0];
        REG_SETTLE_SAMPLES: settle_samples <= cfg_data[SETTLE_W-1:0];
        REG_WINDOW_SAMPLES: window_samples <= cfg_data[WIN_W-1:0];
        REG_RATE_SCALE:     rate_scale     <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: advance the input register whenever the output register frees up
  assign advance      = in_full && (!out_full || out_ch.ready);
  assign in_ch.ready  = !in_full || advance;
  assign out_ch.valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ch.ready) begin
      in_full <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_sample <= in_ch.sample;
    end
  end

  ecg_lbc_biquad u_biquad (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .x       (in_sample),
    .y       (y),
    .y1      (y1),
    .y2      (y2)
  );

  // Peak detection and window counting
  always_comb begin
    counting   = sample_counter >= CNT_W'(settle_samples);
    pos        = sample_counter - CNT_W'(settle_samples);
    peak_hit   = counting
              && ($signed({y[FILT_W-1], y}) > $signed({2'b00, peak_threshold}))
              && (y < y1) && (y1 >= y2);
    window_end = counting && ({1'b0, pos} + (CNT_W+1)'(1) >= (CNT_W+1)'(window_samples));
    count_inc  = peak_hit && (peak_count != {PEAKS_W{1'b1}});
    // Product of the count before this sample, plus one scale step for this sample's peak
    prod = PROD_W'(peak_count) * PROD_W'(rate_scale)
         + (count_inc ? PROD_W'(rate_scale) : '0);
    if (!window_end) begin
      rate = '0;
    end else if (prod > PROD_W'({RATE_W{1'b1}})) begin
      rate = {RATE_W{1'b1}};
    end else begin
      rate = prod[RATE_W-1:0];
    end

    peak_count_next     = peak_count + PEAKS_W'(count_inc);
    sample_counter_next = sample_counter + CNT_W'(1);
    if (window_end) begin
      peak_count_next     = '0;
      sample_counter_next = CNT_W'(settle_samples);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
      peak_count     <= '0;
    end else if (advance) begin
      sample_counter <= sample_counter_next;
      peak_count     <= peak_count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (out_ch.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.filtered   <= y;
      out_ch.peak       <= peak_hit;
      out_ch.rate_valid <= window_end;
      out_ch.beat_rate  <= rate;
    end
  end

endmodule

FILE: dv/ecg_lowpass_beat_counter_unit_test.sv
// Self-checking testbench for the ECG low-pass filter and beat-rate counter.
module ecg_lowpass_beat_counter_unit_test;
  import ecg_lbc_pkg::*;

  function automatic longint coef_from_milli(input longint milli);
    return (milli * (longint'(1) <<< COEF_FRAC_BITS) + 500) / 1000;
  endfunction

  localparam longint COEF_ONE = longint'(1) <<< COEF_FRAC_BITS;
  localparam longint TAP_X0 = coef_from_milli(16);
  localparam longint TAP_X1 = coef_from_milli(32);
  localparam longint TAP_X2 = coef_from_milli(16);
  localparam longint TAP_Y1 = coef_from_milli(1630);
  localparam longint TAP_Y2 = coef_from_milli(691);
  localparam int FILT_HI = 2 ** (FILT_W - 1) - 1;
  localparam int FILT_LO = -(2 ** (FILT_W - 1));
  localparam int RATE_HI = 2 ** RATE_W - 1;
  localparam int PEAKS_HI = 2 ** PEAKS_W - 1;
  localparam int CNT_MASK = 2 ** CNT_W - 1;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_GAP_CYCLES = 4;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    filt_t             filtered;
    logic              peak;
    logic              rate_valid;
    logic [RATE_W-1:0] beat_rate;
  } beat_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ecg_lbc_in_if  in_ch ();
  ecg_lbc_out_if out_ch ();

  ecg_lowpass_beat_counter_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Filter and counter settings as the block holds them
  int threshold_level = int'(RST_PEAK_THRESHOLD);
  int settle_length   = int'(RST_SETTLE_SAMPLES);
  int window_length   = int'(RST_WINDOW_SAMPLES);
  int rate_multiplier = int'(RST_RATE_SCALE);

  // Filter history and window counters
  int x_prev1 = 0;
  int x_prev2 = 0;
  int y_prev1 = 0;
  int y_prev2 = 0;
  int beat_position = 0;
  int window_peaks = 0;

  logic [SAMPLE_BITS-1:0] pending_samples[$];
  beat_result_t expected_results[$];
  int samples_in_flight = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  bit sample_taken = 1'b0;

  int sender_idle_pct = 19;
  int receiver_idle_pct = 52;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  function automatic beat_result_t predict_filter_and_beats(input logic [SAMPLE_BITS-1:0] x0);
    beat_result_t res;
    longint acc;
    longint q;
    int y;
    int pos;
    int prod;
    acc = TAP_X0 * longint'(x0) + TAP_X1 * longint'(x_prev1) + TAP_X2 * longint'(x_prev2)
        + TAP_Y1 * longint'(y_prev1) - TAP_Y2 * longint'(y_prev2);
    // signed division truncates toward zero
    q = acc / COEF_ONE;
    if (q > FILT_HI) q = FILT_HI;
    if (q < FILT_LO) q = FILT_LO;
    y = int'(q);
    res.filtered = filt_t'(y);
    res.peak = 1'b0;
    res.rate_valid = 1'b0;
    res.beat_rate = '0;
    if (beat_position < settle_length) begin
      beat_position = (beat_position + 1) & CNT_MASK;
    end else begin
      pos = beat_position - settle_length;
      if (y > threshold_level && y < y_prev1 && y_prev1 >= y_prev2) begin
        res.peak = 1'b1;
        if (window_peaks < PEAKS_HI) window_peaks++;
      end
      if (pos + 1 >= window_length) begin
        prod = window_peaks * rate_multiplier;
        res.rate_valid = 1'b1;
        res.beat_rate = RATE_W'((prod > RATE_HI) ? RATE_HI : prod);
        window_peaks = 0;
        beat_position = settle_length;
      end else begin
        beat_position = (beat_position + 1) & CNT_MASK;
      end
    end
    x_prev2 = x_prev1;
    x_prev1 = int'(x0);
    y_prev2 = y_prev1;
    y_prev1 = y;
    return res;
  endfunction

  // Sample driver
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || sample_taken) begin
      if (pending_samples.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.sample <= pending_samples.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready, with an occasional long hold-off to back up the pipeline
  always @(negedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
    end
  end

  // Monitor: predict on each accepted sample, check each accepted result
  always @(posedge clk) begin
    beat_result_t want;
    sample_taken = 1'b0;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_filter_and_beats(in_ch.sample));
        sample_taken = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: filtered %0d", $signed(out_ch.filtered));
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          samples_in_flight--;
          if (out_ch.filtered !== want.filtered) begin
            $error("filtered: expected %0d, actual %0d", want.filtered,
                   $signed(out_ch.filtered));
            mismatches++;
          end
          if (out_ch.peak !== want.peak) begin
            $error("peak: expected %0d, actual %0d", want.peak, out_ch.peak);
            mismatches++;
          end
          if (out_ch.rate_valid !== want.rate_valid) begin
            $error("rate_valid: expected %0d, actual %0d", want.rate_valid,
                   out_ch.rate_valid);
            mismatches++;
          end
          if (out_ch.beat_rate !== want.beat_rate) begin
            $error("beat_rate: expected %0d, actual %0d", want.beat_rate,
                   out_ch.beat_rate);
            mismatches++;
          end
        end
      end
      if (sample_taken || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic push_sample(input int v);
    pending_samples.push_back(v[SAMPLE_BITS-1:0]);
    samples_in_flight++;
  endtask

  // Heartbeat-like pulse train on a low baseline, with some samples replaced by noise
  task automatic queue_heartbeats(input int count, input int noise_pct);
    int period;
    int width;
    int level;
    int base;
    int phase;
    period = 1;
    width = 0;
    level = 0;
    base = 0;
    phase = 0;
    for (int i = 0; i < count; i++) begin
      if (phase == 0) begin
        period = $urandom_range(60, 24);
        width = $urandom_range(18, 6);
        level = $urandom_range(1023, 600);
        base = $urandom_range(300, 0);
      end
      if ($urandom_range(99, 0) < noise_pct) push_sample($urandom_range(1023, 0));
      else if (phase < width) push_sample(level - $urandom_range(20, 0));
      else push_sample(base + $urandom_range(20, 0));
      phase = (phase + 1) % period;
    end
  endtask

  // Drain the block and let it settle before touching the registers
  task automatic wait_idle();
    while (samples_in_flight != 0) @(negedge clk);
    repeat (SETTLE_GAP_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    case (idx)
      REG_PEAK_THRESHOLD: threshold_level = value & (2 ** THR_W - 1);
      REG_SETTLE_SAMPLES: settle_length = value & (2 ** SETTLE_W - 1);
      REG_WINDOW_SAMPLES: window_length = value & (2 ** WIN_W - 1);
      REG_RATE_SCALE:     rate_multiplier = value & (2 ** SCALE_W - 1);
      default: ;
    endcase
  endtask

  task automatic program_settings(input int thr, input int settle, input int win,
                                  input int scale);
    wait_idle();
    write_reg(REG_PEAK_THRESHOLD, thr);
    write_reg(REG_SETTLE_SAMPLES, settle);
    write_reg(REG_WINDOW_SAMPLES, win);
    write_reg(REG_RATE_SCALE, scale);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Align to a rising edge so queue updates never race the driver
  task automatic start_phase(input int sender_pct, input int receiver_pct);
    @(posedge clk);
    sender_idle_pct = sender_pct;
    receiver_idle_pct = receiver_pct;
  endtask

  initial begin
    int directed[];
    directed = '{0, 1023, 1023, 0, 0, 512, 511, 1, 2, 4, 8, 16, 32, 64, 128, 256,
                 682, 341, 1023, 1023, 1023, 0, 0};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_PEAK_THRESHOLD;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: extremes and single bits while still settling
    start_phase(19, 52);
    foreach (directed[i]) push_sample(directed[i]);
    queue_heartbeats(100, 10);

    // Window of zero: every counted sample closes a window
    program_settings(300, 10, 0, 3);
    start_phase(19, 52);
    queue_heartbeats(60, 5);

    // Short windows at full scale; hold the receiver off to fill the pipeline
    program_settings($urandom_range(700, 200), 0, $urandom_range(80, 20), 15);
    start_phase(19, 52);
    queue_heartbeats(100, 5);
    hold_requests++;

    // Settling raised above the counter, top threshold, longest window
    program_settings(2047, 4095, 65535, 1);
    start_phase(52, 19);
    queue_heartbeats(40, 100);

    // Scale of zero over a long window
    program_settings(100, 0, 65535, 0);
    start_phase(52, 19);
    queue_heartbeats(50, 5);

    // Shrink the window below the current position: next sample closes it
    program_settings(100, 0, 1, 7);
    start_phase(52, 19);
    queue_heartbeats(40, 5);

    for (int p = 0; p < 4; p++) begin
      program_settings($urandom_range(1100, 0), $urandom_range(30, 0),
                       $urandom_range(100, 1), $urandom_range(15, 1));
      if (p < 2) start_phase(52, 19);
      else start_phase(0, 0);
      queue_heartbeats(30, 20);
    end

    // Small fast ripple above a zero threshold, closing a short window every eight samples
    program_settings(0, 0, 8, 15);
    start_phase(0, 0);
    for (int i = 0; i < 24; i++) push_sample((i % 4 < 2) ? 256 : 768);

    while (samples_in_flight != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
